### design/ppmhp_pkg.sv
// ----------------------------------------------------------------------------
// ppmhp_pkg
// shared types and constants of the binary ppm header parser
// ----------------------------------------------------------------------------
package ppmhp_pkg;

    // depth of the queue between classifier and parser
    localparam int unsigned Q_DEPTH = 4;

    // header characters
    localparam logic [7:0] CH_P     = 8'h50;  // 'P'
    localparam logic [7:0] CH_SIX   = 8'h36;  // '6'
    localparam logic [7:0] CH_NL    = 8'h0A;  // newline
    localparam logic [7:0] CH_HASH  = 8'h23;  // '#'
    localparam logic [7:0] CH_SPACE = 8'h20;  // ' '
    localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'

    localparam logic [31:0] MAXVAL_OK = 32'd255;

    typedef enum logic [1:0] {
        ST_HDR    = 2'd0,
        ST_ACCEPT = 2'd1,
        ST_PIXEL  = 2'd2,
        ST_ERROR  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        ERR_NONE   = 3'd0,
        ERR_MAGIC  = 3'd1,
        ERR_NL     = 3'd2,
        ERR_SHORT  = 3'd3,
        ERR_MAXVAL = 3'd4
    } t_err;

    // classified input byte as it travels through the queue
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
        logic       is_p;
        logic       is_six;
        logic       is_nl;
        logic       is_hash;
        logic       is_term;
    } t_item;

endpackage

### design/ppmhp_in_if.sv
// ----------------------------------------------------------------------------
// ppmhp_in_if
// byte request channel into the header parser
// ----------------------------------------------------------------------------
interface ppmhp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last;

    modport source (output valid, output data_byte, output last, input ready);
    modport sink   (input valid, input data_byte, input last, output ready);
endinterface

### design/ppmhp_out_if.sv
// ----------------------------------------------------------------------------
// ppmhp_out_if
// result request channel out of the header parser
// ----------------------------------------------------------------------------
interface ppmhp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [2:0]  error_kind;
    logic [31:0] width;
    logic [31:0] height;
    logic [31:0] pixel_offset;
    logic [7:0]  pixel_byte;
    logic        last_out;

    modport source (
        output valid, output status, output error_kind, output width, output height,
        output pixel_offset, output pixel_byte, output last_out, input ready
    );
    modport sink (
        input valid, input status, input error_kind, input width, input height,
        input pixel_offset, input pixel_byte, input last_out, output ready
    );
endinterface

### design/ppmhp_front.sv
// ----------------------------------------------------------------------------
// ppmhp_front
// accepts input bytes and tags them with their character class
// ----------------------------------------------------------------------------
module ppmhp_front (
    ppmhp_in_if.sink          i_in,
    input  logic              i_full,
    output logic              o_push,
    output ppmhp_pkg::t_item  o_item
);
    import ppmhp_pkg::*;

    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full;

    always_comb begin
        o_item.data_byte = i_in.data_byte;
        o_item.last      = i_in.last;
        o_item.is_p      = (i_in.data_byte == CH_P);
        o_item.is_six    = (i_in.data_byte == CH_SIX);
        o_item.is_nl     = (i_in.data_byte == CH_NL);
        o_item.is_hash   = (i_in.data_byte == CH_HASH);
        // number terminator: space or newline
        o_item.is_term   = (i_in.data_byte == CH_SPACE) || (i_in.data_byte == CH_NL);
    end

endmodule

### design/ppmhp_queue.sv
// ----------------------------------------------------------------------------
// ppmhp_queue
// short fifo of classified bytes between classifier and parser
// ----------------------------------------------------------------------------
module ppmhp_queue #(
    parameter int unsigned Depth = ppmhp_pkg::Q_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  ppmhp_pkg::t_item  i_item,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output ppmhp_pkg::t_item  o_item
);
    import ppmhp_pkg::*;

    localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int unsigned CntW = $clog2(Depth + 1);

    t_item             r_mem [Depth];
    logic [PtrW-1:0]   r_wr_ptr;
    logic [PtrW-1:0]   r_rd_ptr;
    logic [CntW-1:0]   r_count;
    logic              wr_en;
    logic              rd_en;

    assign o_full  = (r_count == CntW'(Depth));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == PtrW'(Depth - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == PtrW'(Depth - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### design/ppmhp_back.sv
// ----------------------------------------------------------------------------
// ppmhp_back
// header state machine, number accumulation and result register
// ----------------------------------------------------------------------------
module ppmhp_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_item_valid,
    input  ppmhp_pkg::t_item  i_item,
    output logic              o_pop,
    ppmhp_out_if.source       o_out
);
    import ppmhp_pkg::*;

    typedef enum logic [3:0] {
        PH_P, PH_SIX, PH_NL, PH_OPT, PH_COMMENT,
        PH_WIDTH, PH_HEIGHT, PH_MAXVAL, PH_PIXELS, PH_ERROR
    } t_phase;

    // parse state
    t_phase      r_phase, n_phase;
    logic [31:0] r_acc, n_acc;
    logic [31:0] r_width, n_width;
    logic [31:0] r_height, n_height;
    logic [31:0] r_index, n_index;
    logic [31:0] r_offset, n_offset;
    t_err        r_err, n_err;

    // result register
    logic        r_out_valid;
    t_status     r_o_status, n_o_status;
    t_err        r_o_err, n_o_err;
    logic [31:0] r_o_width, n_o_width;
    logic [31:0] r_o_height, n_o_height;
    logic [31:0] r_o_offset, n_o_offset;
    logic [7:0]  r_o_pixel, n_o_pixel;
    logic        r_o_last;

    logic [31:0] acc_step;
    logic        num;
    t_status     status;

    assign o_pop = i_item_valid && (!r_out_valid || o_out.ready);

    // acc * 10 + (byte - '0'), wrapping
    assign acc_step = {r_acc[28:0], 3'b000} + {r_acc[30:0], 1'b0}
                    + {24'd0, i_item.data_byte} - {24'd0, CH_ZERO};

    always_comb begin
        n_phase  = r_phase;
        n_acc    = r_acc;
        n_width  = r_width;
        n_height = r_height;
        n_offset = r_offset;
        n_err    = r_err;
        status   = ST_HDR;
        num      = 1'b0;

        case (r_phase)
            PH_P: begin
                if (!i_item.is_p) begin
                    n_phase = PH_ERROR; n_err = ERR_MAGIC;
                end else if (i_item.last) begin
                    n_phase = PH_ERROR; n_err = ERR_SHORT;
                end else begin
                    n_phase = PH_SIX;
                end
            end
            PH_SIX: begin
                if (!i_item.is_six) begin
                    n_phase = PH_ERROR; n_err = ERR_MAGIC;
                end else if (i_item.last) begin
                    n_phase = PH_ERROR; n_err = ERR_SHORT;
                end else begin
                    n_phase = PH_NL;
                end
            end
            PH_NL: begin
                if (!i_item.is_nl) begin
                    n_phase = PH_ERROR; n_err = ERR_NL;
                end else if (i_item.last) begin
                    n_phase = PH_ERROR; n_err = ERR_SHORT;
                end else begin
                    n_phase = PH_OPT;
                end
            end
            PH_OPT: begin
                if (i_item.is_hash) begin
                    if (i_item.last) begin
                        n_phase = PH_ERROR; n_err = ERR_SHORT;
                    end else begin
                        n_phase = PH_COMMENT;
                    end
                end else begin
                    // no comment: this byte already belongs to the width
                    n_phase = PH_WIDTH;
                    num     = 1'b1;
                end
            end
            PH_COMMENT: begin
                if (i_item.last) begin
                    n_phase = PH_ERROR; n_err = ERR_SHORT;
                end else if (i_item.is_nl) begin
                    n_phase = PH_WIDTH;
                end
            end
            PH_WIDTH, PH_HEIGHT, PH_MAXVAL: begin
                num = 1'b1;
            end
            PH_PIXELS: begin
                status = ST_PIXEL;
            end
            default: begin
            end
        endcase

        if (num) begin
            if (i_item.last) begin
                n_phase = PH_ERROR; n_err = ERR_SHORT;
            end else if (i_item.is_term) begin
                n_acc = '0;
                if (r_phase == PH_WIDTH || r_phase == PH_OPT) begin
                    n_width = r_acc;
                    n_phase = PH_HEIGHT;
                end else if (r_phase == PH_HEIGHT) begin
                    n_height = r_acc;
                    n_phase  = PH_MAXVAL;
                end else if (r_acc != MAXVAL_OK) begin
                    n_phase = PH_ERROR; n_err = ERR_MAXVAL;
                end else begin
                    n_offset = r_index + 32'd1;
                    n_phase  = PH_PIXELS;
                    status   = ST_ACCEPT;
                end
            end else begin
                n_acc = acc_step;
            end
        end

        if (n_phase == PH_ERROR) begin
            status = ST_ERROR;
        end

        // result fields
        n_o_status = status;
        n_o_err    = (status == ST_ERROR) ? n_err : ERR_NONE;
        if (status == ST_ACCEPT || status == ST_PIXEL) begin
            n_o_width  = n_width;
            n_o_height = n_height;
            n_o_offset = n_offset;
        end else begin
            n_o_width  = '0;
            n_o_height = '0;
            n_o_offset = '0;
        end
        n_o_pixel = (status == ST_PIXEL) ? i_item.data_byte : 8'd0;

        // end of buffer restarts the parse
        if (i_item.last) begin
            n_phase  = PH_P;
            n_acc    = '0;
            n_width  = '0;
            n_height = '0;
            n_offset = '0;
            n_err    = ERR_NONE;
            n_index  = '0;
        end else begin
            n_index  = r_index + 32'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_P;
            r_acc       <= '0;
            r_width     <= '0;
            r_height    <= '0;
            r_index     <= '0;
            r_offset    <= '0;
            r_err       <= ERR_NONE;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_phase     <= n_phase;
                r_acc       <= n_acc;
                r_width     <= n_width;
                r_height    <= n_height;
                r_index     <= n_index;
                r_offset    <= n_offset;
                r_err       <= n_err;
                r_out_valid <= 1'b1;
                r_o_status  <= n_o_status;
                r_o_err     <= n_o_err;
                r_o_width   <= n_o_width;
                r_o_height  <= n_o_height;
                r_o_offset  <= n_o_offset;
                r_o_pixel   <= n_o_pixel;
                r_o_last    <= i_item.last;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.status       = r_o_status;
    assign o_out.error_kind   = r_o_err;
    assign o_out.width        = r_o_width;
    assign o_out.height       = r_o_height;
    assign o_out.pixel_offset = r_o_offset;
    assign o_out.pixel_byte   = r_o_pixel;
    assign o_out.last_out     = r_o_last;

endmodule

### design/ppm_header_parser.sv
// ----------------------------------------------------------------------------
// ppm_header_parser
// binary ppm (p6) header parser with pixel byte pass-through
// ----------------------------------------------------------------------------
// usage
//   i_in  : byte requests (data_byte, last), one per cycle at most
//   o_out : one result request per input byte, in the same order
//   the front classifies each byte (magic, newline, hash, terminator) and
//   pushes it into a small fifo; the back runs the header state machine and
//   the number accumulator and loads a result register
// path: an accepted byte goes through the fifo into the result register
// throughput: one byte per cycle while o_out.ready is high, set by the
//   single-step state machine; the result register is refilled in the
//   cycle it is taken
// reset: synchronous, active low; fifo empty, no result valid, parser
//   waiting for the magic 'P'
// stall: while o_out.ready is low the result holds, the fifo takes up to
//   QueueDepth more bytes, then i_in.ready drops
// ----------------------------------------------------------------------------
module ppm_header_parser #(
    parameter int unsigned QueueDepth = ppmhp_pkg::Q_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ppmhp_in_if.sink     i_in,
    ppmhp_out_if.source  o_out
);
    import ppmhp_pkg::*;

    // front to fifo
    logic  push;
    logic  full;
    t_item push_item;

    // fifo to back
    logic  q_valid;
    logic  pop;
    t_item q_item;

    // byte classification and input handshake
    ppmhp_front u_front (
        .i_in   (i_in),
        .i_full (full),
        .o_push (push),
        .o_item (push_item)
    );

    // decoupling fifo so either side can stall alone
    ppmhp_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    // header state machine and result register
    ppmhp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (q_valid),
        .i_item       (q_item),
        .o_pop        (pop),
        .o_out        (o_out)
    );

endmodule

### design/ppmhp_checker.sv
// ----------------------------------------------------------------------------
// ppmhp_checker
// port-level checks of the header parser, bound to the top level
// ----------------------------------------------------------------------------
module ppmhp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  i_status,
    input logic [2:0]  i_error_kind,
    input logic [31:0] i_width,
    input logic [31:0] i_height,
    input logic [31:0] i_offset,
    input logic [7:0]  i_pixel_byte
);
    import ppmhp_pkg::*;

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_status)
            && $stable(i_error_kind) && $stable(i_pixel_byte))
        else $error("stalled result changed");

    // error code only with error status
    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status != ST_ERROR) |-> (i_error_kind == ERR_NONE))
        else $error("error code without error status");

    // header fields only after acceptance
    a_dims: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == ST_HDR || i_status == ST_ERROR)
            |-> (i_width == '0) && (i_height == '0) && (i_offset == '0))
        else $error("header fields before acceptance");

    // pixel byte only with pixel status
    a_pix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status != ST_PIXEL) |-> (i_pixel_byte == 8'd0))
        else $error("pixel byte outside pixel data");

endmodule

bind ppm_header_parser ppmhp_checker u_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_status     (o_out.status),
    .i_error_kind (o_out.error_kind),
    .i_width      (o_out.width),
    .i_height     (o_out.height),
    .i_offset     (o_out.pixel_offset),
    .i_pixel_byte (o_out.pixel_byte)
);

### dv/ppm_header_parser_tb.sv
// ----------------------------------------------------------------------------
// ppm_header_parser_tb
// self-checking bench for the binary ppm header parser: a short table of
// hand-checked byte requests, then random image buffers (mostly well-formed
// headers with random numbers, comments and pixels, plus cut, corrupted,
// bad-maxval and noise buffers) scored against a cycle-free parser model
// ----------------------------------------------------------------------------
module ppm_header_parser_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import ppmhp_pkg::*;

    // run shape
    localparam int RANDOM_ITEMS   = 750;
    localparam int QUIET_TAIL     = 100;     // last requests sent with no idling
    localparam int CALM_FROM      = 300;     // idle-free stretch in the middle
    localparam int CALM_TO        = 380;
    localparam int RX_HOLD_CYCLES = 80;      // long receiver hold-off, fills the fifo
    localparam int DRAIN_CYCLES   = 10;      // drain margin after the last expected result
    localparam int CYCLE_LIMIT    = 200000;

    // header walk of the model parser
    typedef enum logic [3:0] {
        WAIT_P,
        WAIT_SIX,
        WAIT_NL,
        MAYBE_COMMENT,
        IN_COMMENT,
        READ_WIDTH,
        READ_HEIGHT,
        READ_MAXVAL,
        PASS_PIXELS,
        LATCHED_ERR
    } t_hdr_phase;

    // kinds of random buffers
    typedef enum logic [2:0] {
        FR_GOOD,
        FR_CUT,
        FR_CORRUPT,
        FR_BAD_MAXVAL,
        FR_NOISE
    } t_frame_kind;

    // one result request
    typedef struct packed {
        t_status     status;
        t_err        err;
        logic [31:0] width;
        logic [31:0] height;
        logic [31:0] offset;
        logic [7:0]  pix;
        logic        last;
    } t_result;

    // one row of the directed table, with its hand-read result
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        t_result    want;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;

    ppmhp_in_if  in_ch ();
    ppmhp_out_if out_ch ();

    ppm_header_parser dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    // model parser state
    t_hdr_phase  hdr_phase;
    logic [31:0] num_acc;
    logic [31:0] width_q;
    logic [31:0] height_q;
    logic [31:0] byte_pos;
    logic [31:0] pix_offset_q;
    t_err        fail_code;

    t_result     parse_results_q[$];   // predicted results, oldest first
    t_dir_row    dir_rows[$];
    logic [7:0]  frame_q[$];           // buffer being built

    int          sent_cnt     = 0;
    int          mismatch_cnt = 0;
    int          cycle_cnt    = 0;
    bit          tx_idle_on;
    bit          rx_idle_on;
    bit          rx_hold_req;
    t_result     oldest_res;

    // ------------------------------------------------------------------------
    // clock
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // model parser
    // ------------------------------------------------------------------------

    // back to waiting for the magic, everything cleared
    function automatic void restart_parse();
        hdr_phase    = WAIT_P;
        num_acc      = '0;
        width_q      = '0;
        height_q     = '0;
        byte_pos     = '0;
        pix_offset_q = '0;
        fail_code    = ERR_NONE;
    endfunction

    function automatic void latch_error(input t_err code);
        hdr_phase = LATCHED_ERR;
        fail_code = code;
    endfunction

    // advance the model by one byte and return the result it causes
    function automatic t_result parse_byte(input logic [7:0] b, input logic l);
        t_result     r;
        t_status     st;
        t_hdr_phase  ph;
        logic        took_hash;
        logic [31:0] num;
        st        = ST_HDR;
        ph        = hdr_phase;
        took_hash = 1'b0;
        num       = '0;

        // the byte after the magic newline either opens a comment or is
        // already the first byte of the width
        if (ph == MAYBE_COMMENT) begin
            if (b == CH_HASH) begin
                if (l) latch_error(ERR_SHORT);
                else hdr_phase = IN_COMMENT;
                took_hash = 1'b1;
            end else begin
                hdr_phase = READ_WIDTH;
                ph        = READ_WIDTH;
            end
        end

        if (!took_hash) begin
            case (ph)
                WAIT_P: begin
                    if (b != CH_P) latch_error(ERR_MAGIC);
                    else if (l) latch_error(ERR_SHORT);
                    else hdr_phase = WAIT_SIX;
                end
                WAIT_SIX: begin
                    if (b != CH_SIX) latch_error(ERR_MAGIC);
                    else if (l) latch_error(ERR_SHORT);
                    else hdr_phase = WAIT_NL;
                end
                WAIT_NL: begin
                    if (b != CH_NL) latch_error(ERR_NL);
                    else if (l) latch_error(ERR_SHORT);
                    else hdr_phase = MAYBE_COMMENT;
                end
                IN_COMMENT: begin
                    if (l) latch_error(ERR_SHORT);
                    else if (b == CH_NL) hdr_phase = READ_WIDTH;
                end
                READ_WIDTH, READ_HEIGHT, READ_MAXVAL: begin
                    // a last byte here is always too early, even the maxval end
                    if (l) begin
                        latch_error(ERR_SHORT);
                    end else if (b == CH_SPACE || b == CH_NL) begin
                        num     = num_acc;
                        num_acc = '0;
                        if (ph == READ_WIDTH) begin
                            width_q   = num;
                            hdr_phase = READ_HEIGHT;
                        end else if (ph == READ_HEIGHT) begin
                            height_q  = num;
                            hdr_phase = READ_MAXVAL;
                        end else if (num != MAXVAL_OK) begin
                            latch_error(ERR_MAXVAL);
                        end else begin
                            pix_offset_q = byte_pos + 32'd1;
                            hdr_phase    = PASS_PIXELS;
                            st           = ST_ACCEPT;
                        end
                    end else begin
                        // no digit check, wraps at 32 bits
                        num_acc = num_acc * 32'd10 + ({24'd0, b} - {24'd0, CH_ZERO});
                    end
                end
                PASS_PIXELS: st = ST_PIXEL;
                default: ;
            endcase
        end

        if (hdr_phase == LATCHED_ERR) st = ST_ERROR;

        r.status = st;
        r.err    = (st == ST_ERROR) ? fail_code : ERR_NONE;
        if (st == ST_ACCEPT || st == ST_PIXEL) begin
            r.width  = width_q;
            r.height = height_q;
            r.offset = pix_offset_q;
        end else begin
            r.width  = '0;
            r.height = '0;
            r.offset = '0;
        end
        r.pix  = (st == ST_PIXEL) ? b : 8'd0;
        r.last = l;

        if (l) restart_parse();
        else byte_pos = byte_pos + 32'd1;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // directed table, width and height are zero in every row
    // ------------------------------------------------------------------------
    function automatic void add_row(input logic [7:0] b, input logic l, input t_status st,
                                    input t_err err, input logic [31:0] off,
                                    input logic [7:0] pix);
        t_dir_row row;
        row.data        = b;
        row.last        = l;
        row.want.status = st;
        row.want.err    = err;
        row.want.width  = '0;
        row.want.height = '0;
        row.want.offset = off;
        row.want.pix    = pix;
        row.want.last   = l;
        dir_rows.push_back(row);
    endfunction

    // ------------------------------------------------------------------------
    // random buffers
    // ------------------------------------------------------------------------
    function automatic void push_text(input string s);
        for (int i = 0; i < s.len(); i++) frame_q.push_back(s[i]);
    endfunction

    // any byte that does not end a number
    function automatic logic [7:0] junk_byte();
        logic [7:0] j;
        j = 8'($urandom_range(0, 255));
        if (j == CH_SPACE || j == CH_NL) j = 8'h7F;
        return j;
    endfunction

    // a number field: empty, largest, overflowing, with junk, or plain
    function automatic void push_number();
        int unsigned sel;
        int unsigned n;
        sel = $urandom_range(0, 9);
        case (sel)
            0: ;
            1: push_text("4294967295");
            2: begin
                n = $urandom_range(11, 13);
                for (int i = 0; i < n; i++)
                    frame_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
            end
            3: begin
                push_text($sformatf("%0d", $urandom_range(0, 99)));
                frame_q.push_back(junk_byte());
                push_text($sformatf("%0d", $urandom_range(0, 9)));
            end
            4: push_text($sformatf("%0d", $urandom()));
            default: push_text($sformatf("%0d", $urandom_range(0, 5000)));
        endcase
    endfunction

    function automatic void push_separator();
        frame_q.push_back($urandom_range(0, 1) ? CH_SPACE : CH_NL);
    endfunction

    function automatic void build_frame();
        t_frame_kind kind;
        int unsigned sel;
        int unsigned hdr_len;
        int unsigned n;
        int unsigned maxv;
        int unsigned cut;
        sel = $urandom_range(0, 11);
        case (sel)
            7, 8:    kind = FR_CUT;
            9:       kind = FR_CORRUPT;
            10:      kind = FR_BAD_MAXVAL;
            11:      kind = FR_NOISE;
            default: kind = FR_GOOD;
        endcase

        frame_q.delete();
        push_text("P6\n");
        if ($urandom_range(0, 1)) begin
            frame_q.push_back(CH_HASH);
            n = $urandom_range(0, 6);
            for (int i = 0; i < n; i++) begin
                frame_q.push_back(8'($urandom_range(0, 255)));
                if (frame_q[frame_q.size() - 1] == CH_NL) frame_q[frame_q.size() - 1] = CH_HASH;
            end
            frame_q.push_back(CH_NL);
        end
        push_number();
        push_separator();
        push_number();
        push_separator();
        if (kind == FR_BAD_MAXVAL) begin
            maxv = $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 600);
            if (maxv == 255) maxv = 256;
            push_text($sformatf("%0d", maxv));
        end else begin
            push_text("255");
        end
        push_separator();
        hdr_len = frame_q.size();

        // pixels, mostly a few, now and then a longer run
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
        for (int i = 0; i < n; i++) frame_q.push_back(8'($urandom_range(0, 255)));

        case (kind)
            FR_CUT: begin
                // a cut at the full header length ends on the maxval terminator
                cut = $urandom_range(1, hdr_len);
                while (frame_q.size() > cut) void'(frame_q.pop_back());
            end
            FR_CORRUPT: frame_q[$urandom_range(0, hdr_len - 1)] = 8'($urandom_range(0, 255));
            FR_NOISE: begin
                frame_q.delete();
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++) frame_q.push_back(8'($urandom_range(0, 255)));
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // request sender: optional idle burst, then offer the byte until taken;
    // valid stays up into the next request when there is no idle
    // ------------------------------------------------------------------------
    task automatic push_byte(input logic [7:0] b, input logic l, input bit use_want,
                             input t_result want);
        t_result r;
        if (tx_idle_on && $urandom_range(0, 5) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= b;
        in_ch.last      <= l;
        do @(posedge i_clk); while (!in_ch.ready);
        // taken at this edge: the model always steps, a hand-read row wins
        r = parse_byte(b, l);
        parse_results_q.push_back(use_want ? want : r);
        sent_cnt++;
    endtask

    // ------------------------------------------------------------------------
    // receiver: random stall bursts, one long hold-off on request
    // ------------------------------------------------------------------------
    initial begin
        out_ch.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (rx_hold_req) begin
                out_ch.ready <= 1'b0;
                rx_hold_req = 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
            end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // result checker
    // ------------------------------------------------------------------------
    function automatic void check_field(input string fname, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
            mismatch_cnt++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (parse_results_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual status %0d",
                         $time, out_ch.status);
                mismatch_cnt++;
            end else begin
                oldest_res = parse_results_q.pop_front();
                check_field("status", 32'(oldest_res.status), 32'(out_ch.status));
                check_field("error_kind", 32'(oldest_res.err), 32'(out_ch.error_kind));
                check_field("width", oldest_res.width, out_ch.width);
                check_field("height", oldest_res.height, out_ch.height);
                check_field("pixel_offset", oldest_res.offset, out_ch.pixel_offset);
                check_field("pixel_byte", 32'(oldest_res.pix), 32'(out_ch.pixel_byte));
                check_field("last_out", 32'(oldest_res.last), 32'(out_ch.last_out));
            end
        end
    end

    // ------------------------------------------------------------------------
    // watchdog
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results still expected", $time, parse_results_q.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n         <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.data_byte <= 8'd0;
        in_ch.last      <= 1'b0;
        restart_parse();
        tx_idle_on  = 1'b1;
        rx_idle_on  = 1'b1;
        rx_hold_req = 1'b0;

        // bad magic on a single-byte buffer
        add_row("X", 1'b1, ST_ERROR, ERR_MAGIC, 0, 0);
        // 'P' as the whole buffer, the '6' is missing
        add_row(CH_P, 1'b1, ST_ERROR, ERR_SHORT, 0, 0);
        // magic without its newline, the check error wins over the end
        add_row(CH_P, 1'b0, ST_HDR, ERR_NONE, 0, 0);
        add_row(CH_SIX, 1'b0, ST_HDR, ERR_NONE, 0, 0);
        add_row("A", 1'b1, ST_ERROR, ERR_NL, 0, 0);
        // comment never closed before the end
        add_row(CH_P, 1'b0, ST_HDR, ERR_NONE, 0, 0);
        add_row(CH_SIX, 1'b0, ST_HDR, ERR_NONE, 0, 0);
        add_row(CH_NL, 1'b0, ST_HDR, ERR_NONE, 0, 0);
        add_row(CH_HASH, 1'b0, ST_HDR, ERR_NONE, 0, 0);
        add_row("z", 1'b1, ST_ERROR, ERR_SHORT, 0, 0);
        // empty width and height, maxval 255 ends at index 8, pixels at 9
        add_row(CH_P, 1'b0, ST_HDR, ERR_NONE, 0, 0);
        add_row(CH_SIX, 1'b0, ST_HDR, ERR_NONE, 0, 0);
        add_row(CH_NL, 1'b0, ST_HDR, ERR_NONE, 0, 0);
        add_row(CH_SPACE, 1'b0, ST_HDR, ERR_NONE, 0, 0);
        add_row(CH_NL, 1'b0, ST_HDR, ERR_NONE, 0, 0);
        add_row("2", 1'b0, ST_HDR, ERR_NONE, 0, 0);
        add_row("5", 1'b0, ST_HDR, ERR_NONE, 0, 0);
        add_row("5", 1'b0, ST_HDR, ERR_NONE, 0, 0);
        add_row(CH_SPACE, 1'b0, ST_ACCEPT, ERR_NONE, 9, 0);
        add_row(8'hFF, 1'b0, ST_PIXEL, ERR_NONE, 9, 8'hFF);
        add_row(8'h00, 1'b1, ST_PIXEL, ERR_NONE, 9, 8'h00);
        // empty maxval reads as zero, error held through the last byte
        add_row(CH_P, 1'b0, ST_HDR, ERR_NONE, 0, 0);
        add_row(CH_SIX, 1'b0, ST_HDR, ERR_NONE, 0, 0);
        add_row(CH_NL, 1'b0, ST_HDR, ERR_NONE, 0, 0);
        add_row(CH_SPACE, 1'b0, ST_HDR, ERR_NONE, 0, 0);
        add_row(CH_SPACE, 1'b0, ST_HDR, ERR_NONE, 0, 0);
        add_row(CH_SPACE, 1'b0, ST_ERROR, ERR_MAXVAL, 0, 0);
        add_row("Q", 1'b1, ST_ERROR, ERR_MAXVAL, 0, 0);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < dir_rows.size(); i++)
            push_byte(dir_rows[i].data, dir_rows[i].last, 1'b1, dir_rows[i].want);

        // the receiver holds off early in the random part while bytes keep coming
        rx_hold_req = 1'b1;

        while (sent_cnt < dir_rows.size() + RANDOM_ITEMS) begin
            tx_idle_on = (sent_cnt < CALM_FROM || sent_cnt >= CALM_TO)
                      && (sent_cnt < dir_rows.size() + RANDOM_ITEMS - QUIET_TAIL);
            rx_idle_on = tx_idle_on;
            build_frame();
            for (int i = 0; i < frame_q.size(); i++)
                push_byte(frame_q[i], i == frame_q.size() - 1, 1'b0, '0);
        end
        in_ch.valid <= 1'b0;

        while (parse_results_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_cnt == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
